@@ sv/assert_macros.svh @@
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define FMOC_ASSERT(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed");
`define FMOC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define FMOC_ASSERT(lbl, clk, rstn, cond)
`define FMOC_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ sv/fmoc_pkg.sv @@
`default_nettype none
package fmoc_pkg;

    localparam int REQ_W  = 2;
    localparam int CHAR_W = 8;
    localparam int POS_W  = 17;
    localparam int CNT_W  = 17;
    localparam int STAT_W = 2;

    localparam int TEXT_DEPTH_DEF = 65536;
    localparam int BLOCK_LEN_DEF  = 64;
    localparam int CLASSES_DEF    = 98;

    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_VT     = 8'd11;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_CTL_LO = 8'd14;
    localparam logic [7:0] CH_CTL_HI = 8'd31;
    localparam logic [7:0] CH_PRINT  = 8'd32;
    localparam logic [7:0] CLS_OFS   = 8'd29;
    localparam logic [7:0] CLS_CR    = 8'd2;
    localparam logic [7:0] CLS_CTL   = 8'd3;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND  = 2'd0,
        REQ_OCC     = 2'd1,
        REQ_CLOOKUP = 2'd2,
        REQ_CLEAR   = 2'd3
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_ALPHA = 2'd1,
        ST_FULL  = 2'd2
    } stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APP,
        S_COPY,
        S_DIV,
        S_CKPT,
        S_CKW,
        S_SCAN,
        S_SUM,
        S_DONE
    } state_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] cls;
    } cls_res_t;

    function automatic cls_res_t class_of(input logic [7:0] b, input int classes);
        cls_res_t r;
        r.ok  = 1'b0;
        r.cls = '0;
        if (b == CH_TAB) begin
            r.ok = 1'b1;
            r.cls = 8'd0;
        end else if (b == CH_LF) begin
            r.ok = 1'b1;
            r.cls = 8'd1;
        end else if (b >= CH_VT && b <= CH_CR) begin
            r.ok = 1'b1;
            r.cls = CLS_CR;
        end else if (b >= CH_CTL_LO && b <= CH_CTL_HI) begin
            r.ok = 1'b1;
            r.cls = CLS_CTL;
        end else if (b >= CH_PRINT && int'(b - CLS_OFS) < classes) begin
            r.ok = 1'b1;
            r.cls = b - CLS_OFS;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ sv/fmoc_if.sv @@
`default_nettype none
interface fmoc_req_if import fmoc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [CHAR_W-1:0] char_code;
    logic [POS_W-1:0]  position;
    modport source(output valid, req_type, char_code, position, input ready);
    modport sink(input valid, req_type, char_code, position, output ready);
endinterface

interface fmoc_rsp_if import fmoc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CNT_W-1:0]  count;
    logic [STAT_W-1:0] status;
    modport source(output valid, count, status, input ready);
    modport sink(input valid, count, status, output ready);
endinterface
`default_nettype wire

@@ sv/fmoc_ram.sv @@
`default_nettype none
module fmoc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ sv/fmoc_blkdiv.sv @@
`default_nettype none
module fmoc_blkdiv #(
    parameter int LEN_W = 17,
    parameter int BLOCK_LEN = 64,
    localparam int BO_W = $clog2(BLOCK_LEN)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [LEN_W-1:0] dividend,
    output logic                  done,
    output logic      [LEN_W-1:0] quot,
    output logic      [BO_W-1:0]  rem
);
    localparam int SH  = LEN_W + BO_W;
    localparam int M_W = LEN_W + 2;
    localparam int P_W = LEN_W + M_W;
    localparam logic [63:0] RECIP_L = ((64'd1 << SH) + 64'(BLOCK_LEN - 1)) / 64'(BLOCK_LEN);
    localparam logic [M_W-1:0] RECIP = M_W'(RECIP_L);

    logic             s1_reg, s1_next;
    logic             done_reg, done_next;
    logic [P_W-1:0]   prod_reg, prod_next;
    logic [LEN_W-1:0] dvd_reg, dvd_next;
    logic [LEN_W-1:0] quot_reg, quot_next;
    logic [BO_W-1:0]  rem_reg, rem_next;
    logic [LEN_W-1:0] quot_c;
    logic [LEN_W-1:0] back_c;

    // quotient by reciprocal multiplication, remainder by multiplying back
    always_comb
    begin
        quot_c    = LEN_W'(prod_reg >> SH);
        back_c    = LEN_W'(quot_c * LEN_W'(BLOCK_LEN));
        s1_next   = start;
        done_next = s1_reg;
        prod_next = prod_reg;
        dvd_next  = dvd_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            prod_next = P_W'(dividend) * P_W'(RECIP);
            dvd_next  = dividend;
        end
        if (s1_reg)
        begin
            quot_next = quot_c;
            rem_next  = BO_W'(dvd_reg - back_c);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= 1'b0;
            done_reg <= 1'b0;
            prod_reg <= '0;
            dvd_reg  <= '0;
            quot_reg <= '0;
            rem_reg  <= '0;
        end else
        begin
            s1_reg   <= s1_next;
            done_reg <= done_next;
            prod_reg <= prod_next;
            dvd_reg  <= dvd_next;
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;
endmodule
`default_nettype wire

@@ sv/fm_index_occurrence_counter.sv @@
`default_nettype none
`include "assert_macros.svh"
// FM-index occurrence counter. One request word in, one result word out, one
// request at a time. A clear or a rejected word goes straight to the final
// state; an append writes the text memory and its running count, and when it
// completes a block the class counts are also copied into a checkpoint row.
// An occurrence query passes the reciprocal block divider, the checkpoint
// read and a byte scan of q mod BLOCK_LEN bytes through the text memory read
// port. A C lookup reads one running count per cycle. A result waits in the
// output register while the next request word is taken; a word that finds
// that register still full waits in the final state until the result has been
// taken.
module fm_index_occurrence_counter import fmoc_pkg::*; #(
    parameter int TEXT_DEPTH = TEXT_DEPTH_DEF,
    parameter int BLOCK_LEN  = BLOCK_LEN_DEF,
    parameter int CLASSES    = CLASSES_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    fmoc_req_if.sink   req,
    fmoc_rsp_if.source rsp
);
    localparam int LEN_W    = $clog2(TEXT_DEPTH + 1);
    localparam int TA_W     = $clog2(TEXT_DEPTH);
    localparam int BO_W     = $clog2(BLOCK_LEN);
    localparam int CLS_W    = $clog2(CLASSES);
    localparam int K_W      = CLS_W + 1;
    localparam int CK_DEPTH = (TEXT_DEPTH / BLOCK_LEN) * CLASSES;
    localparam int CK_AW    = $clog2(CK_DEPTH);
    localparam int CMP_W    = (LEN_W > POS_W) ? LEN_W : POS_W;
    localparam int MUL_W    = LEN_W + 9;

    state_t state_reg, state_next;

    logic [REQ_W-1:0]  type_reg, type_next;
    logic [CHAR_W-1:0] ch_reg, ch_next;
    logic [CLS_W-1:0]  cls_reg, cls_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [BO_W-1:0]   boff_reg, boff_next;
    logic [CK_AW-1:0]  base_reg, base_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic              pend_reg, pend_next;
    logic [CLS_W-1:0]  pidx_reg, pidx_next;
    logic              pvld_reg, pvld_next;
    logic [CNT_W-1:0]  acc_reg, acc_next;
    logic [STAT_W-1:0] st_reg, st_next;
    logic [LEN_W-1:0]  q_reg, q_next;
    logic [CK_AW-1:0]  ckaddr_reg, ckaddr_next;
    logic              blknz_reg, blknz_next;
    logic [TA_W-1:0]   saddr_reg, saddr_next;
    logic [BO_W-1:0]   left_reg, left_next;
    logic [CLASSES-1:0] valid_reg, valid_next;
    logic              ovalid_reg, ovalid_next;
    logic [CNT_W-1:0]  ocount_reg, ocount_next;
    logic [STAT_W-1:0] ostatus_reg, ostatus_next;

    logic              accept;
    cls_res_t          cres;
    logic [CLS_W-1:0]  cls_in;
    logic [LEN_W-1:0]  q_in;
    logic              is_full;
    logic              out_load;
    logic              div_start, div_done;
    logic [LEN_W-1:0]  div_quot;
    logic [BO_W-1:0]   div_rem;
    logic [MUL_W-1:0]  ck_prod;

    logic              txt_we;
    logic [TA_W-1:0]   txt_waddr, txt_raddr;
    logic [CHAR_W-1:0] txt_wdata, txt_rdata;
    logic              ck_we;
    logic [CK_AW-1:0]  ck_waddr, ck_raddr;
    logic [CNT_W-1:0]  ck_wdata, ck_rdata;
    logic              run_we;
    logic [CLS_W-1:0]  run_waddr, run_raddr;
    logic [CNT_W-1:0]  run_wdata, run_rdata;
    logic [CNT_W-1:0]  run_val;

    assign accept   = req.valid && req.ready;
    assign cres     = class_of(req.char_code, CLASSES);
    assign cls_in   = CLS_W'(cres.cls);
    assign q_in     = (CMP_W'(req.position) < CMP_W'(len_reg))
                      ? LEN_W'(req.position) : len_reg;
    assign is_full  = len_reg == LEN_W'(TEXT_DEPTH);
    assign out_load = !ovalid_reg || rsp.ready;
    assign run_val  = pvld_reg ? run_rdata : '0;
    assign ck_prod  = MUL_W'(div_quot - 1'b1) * MUL_W'(CLASSES);

    assign req.ready  = state_reg == S_IDLE;
    assign rsp.valid  = ovalid_reg;
    assign rsp.count  = ocount_reg;
    assign rsp.status = ostatus_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.req_type == REQ_CLEAR || !cres.ok)
                        state_next = S_DONE;
                    else if (req.req_type == REQ_APPEND)
                        state_next = is_full ? S_DONE : S_APP;
                    else if (req.req_type == REQ_OCC)
                        state_next = S_DIV;
                    else
                        state_next = S_SUM;
                end
            end
            S_APP:  state_next = (boff_reg == BO_W'(BLOCK_LEN - 1)) ? S_COPY : S_DONE;
            S_COPY:
            begin
                if (k_reg == K_W'(CLASSES) && !pend_reg)
                    state_next = S_DONE;
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_CKPT;
            end
            S_CKPT: state_next = S_CKW;
            S_CKW:  state_next = S_SCAN;
            S_SCAN:
            begin
                if (left_reg == '0 && !pend_reg)
                    state_next = S_DONE;
            end
            S_SUM:
            begin
                if (k_reg == K_W'(cls_reg) && !pend_reg)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        type_next    = type_reg;
        ch_next      = ch_reg;
        cls_next     = cls_reg;
        len_next     = len_reg;
        boff_next    = boff_reg;
        base_next    = base_reg;
        k_next       = k_reg;
        pend_next    = 1'b0;
        pidx_next    = pidx_reg;
        pvld_next    = pvld_reg;
        acc_next     = acc_reg;
        st_next      = st_reg;
        q_next       = q_reg;
        ckaddr_next  = ckaddr_reg;
        blknz_next   = blknz_reg;
        saddr_next   = saddr_reg;
        left_next    = left_reg;
        valid_next   = valid_reg;
        ovalid_next  = ovalid_reg && !rsp.ready;
        ocount_next  = ocount_reg;
        ostatus_next = ostatus_reg;
        div_start    = 1'b0;
        txt_we       = 1'b0;
        txt_waddr    = TA_W'(len_reg);
        txt_wdata    = req.char_code;
        txt_raddr    = saddr_reg;
        ck_we        = 1'b0;
        ck_waddr     = CK_AW'(base_reg + CK_AW'(pidx_reg));
        ck_wdata     = run_val;
        ck_raddr     = ckaddr_reg;
        run_we       = 1'b0;
        run_waddr    = cls_reg;
        run_wdata    = run_val + 1'b1;
        run_raddr    = k_reg[CLS_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    type_next = req.req_type;
                    ch_next   = req.char_code;
                    cls_next  = cls_in;
                    acc_next  = '0;
                    st_next   = ST_OK;
                    k_next    = '0;
                    q_next    = q_in;
                    run_raddr = cls_in;
                    pvld_next = valid_reg[cls_in];
                    if (req.req_type == REQ_CLEAR)
                    begin
                        len_next   = '0;
                        boff_next  = '0;
                        base_next  = '0;
                        valid_next = '0;
                    end else if (!cres.ok)
                    begin
                        st_next = ST_ALPHA;
                    end else if (req.req_type == REQ_APPEND)
                    begin
                        if (is_full)
                            st_next = ST_FULL;
                        else
                            txt_we = 1'b1;
                    end else if (req.req_type == REQ_OCC)
                    begin
                        div_start = 1'b1;
                    end
                end
            end
            S_APP:
            begin
                run_we             = 1'b1;
                valid_next[cls_reg] = 1'b1;
                len_next           = len_reg + 1'b1;
                if (boff_reg == BO_W'(BLOCK_LEN - 1))
                    boff_next = '0;
                else
                    boff_next = boff_reg + 1'b1;
            end
            S_COPY:
            begin
                if (k_reg != K_W'(CLASSES))
                begin
                    pend_next = 1'b1;
                    pidx_next = k_reg[CLS_W-1:0];
                    pvld_next = valid_reg[k_reg[CLS_W-1:0]];
                    k_next    = k_reg + 1'b1;
                end
                if (pend_reg)
                    ck_we = 1'b1;
                if (k_reg == K_W'(CLASSES) && !pend_reg)
                    base_next = CK_AW'(base_reg + CK_AW'(CLASSES));
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    blknz_next  = div_quot != '0;
                    ckaddr_next = CK_AW'(ck_prod) + CK_AW'(cls_reg);
                    saddr_next  = TA_W'(q_reg - LEN_W'(div_rem));
                    left_next   = div_rem;
                end
            end
            S_CKPT: ;
            S_CKW:
            begin
                acc_next = blknz_reg ? ck_rdata : '0;
            end
            S_SCAN:
            begin
                if (left_reg != '0)
                begin
                    pend_next  = 1'b1;
                    saddr_next = saddr_reg + 1'b1;
                    left_next  = left_reg - 1'b1;
                end
                if (pend_reg && txt_rdata == ch_reg)
                    acc_next = acc_reg + 1'b1;
            end
            S_SUM:
            begin
                if (k_reg != K_W'(cls_reg))
                begin
                    pend_next = 1'b1;
                    pvld_next = valid_reg[k_reg[CLS_W-1:0]];
                    k_next    = k_reg + 1'b1;
                end
                if (pend_reg)
                    acc_next = acc_reg + run_val;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    ovalid_next  = 1'b1;
                    ocount_next  = acc_reg;
                    ostatus_next = st_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            type_reg    <= '0;
            ch_reg      <= '0;
            cls_reg     <= '0;
            len_reg     <= '0;
            boff_reg    <= '0;
            base_reg    <= '0;
            k_reg       <= '0;
            pend_reg    <= 1'b0;
            pidx_reg    <= '0;
            pvld_reg    <= 1'b0;
            acc_reg     <= '0;
            st_reg      <= '0;
            q_reg       <= '0;
            ckaddr_reg  <= '0;
            blknz_reg   <= 1'b0;
            saddr_reg   <= '0;
            left_reg    <= '0;
            valid_reg   <= '0;
            ovalid_reg  <= 1'b0;
            ocount_reg  <= '0;
            ostatus_reg <= '0;
        end else
        begin
            state_reg   <= state_next;
            type_reg    <= type_next;
            ch_reg      <= ch_next;
            cls_reg     <= cls_next;
            len_reg     <= len_next;
            boff_reg    <= boff_next;
            base_reg    <= base_next;
            k_reg       <= k_next;
            pend_reg    <= pend_next;
            pidx_reg    <= pidx_next;
            pvld_reg    <= pvld_next;
            acc_reg     <= acc_next;
            st_reg      <= st_next;
            q_reg       <= q_next;
            ckaddr_reg  <= ckaddr_next;
            blknz_reg   <= blknz_next;
            saddr_reg   <= saddr_next;
            left_reg    <= left_next;
            valid_reg   <= valid_next;
            ovalid_reg  <= ovalid_next;
            ocount_reg  <= ocount_next;
            ostatus_reg <= ostatus_next;
        end
    end

    fmoc_blkdiv #(.LEN_W(LEN_W), .BLOCK_LEN(BLOCK_LEN)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (q_in),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    fmoc_ram #(.WIDTH(CHAR_W), .DEPTH(TEXT_DEPTH)) u_text (
        .clk   (clk),
        .we    (txt_we),
        .waddr (txt_waddr),
        .wdata (txt_wdata),
        .raddr (txt_raddr),
        .rdata (txt_rdata)
    );

    fmoc_ram #(.WIDTH(CNT_W), .DEPTH(CK_DEPTH)) u_ckpt (
        .clk   (clk),
        .we    (ck_we),
        .waddr (ck_waddr),
        .wdata (ck_wdata),
        .raddr (ck_raddr),
        .rdata (ck_rdata)
    );

    fmoc_ram #(.WIDTH(CNT_W), .DEPTH(CLASSES)) u_run (
        .clk   (clk),
        .we    (run_we),
        .waddr (run_waddr),
        .wdata (run_wdata),
        .raddr (run_raddr),
        .rdata (run_rdata)
    );

    `FMOC_ASSERT(a_len_max, clk, rst_n, len_reg <= LEN_W'(TEXT_DEPTH))
    `FMOC_ASSERT(a_boff_range, clk, rst_n, boff_reg <= BO_W'(BLOCK_LEN - 1))
    `FMOC_ASSERT_IMPL(a_app_type, clk, rst_n, state_reg == S_APP, type_reg == REQ_APPEND)
endmodule
`default_nettype wire
